// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the terminal line editor.
// No dependencies.
package tle_pkg;

    localparam int LINE_SIZE = 16;
    localparam int LEN_W     = $clog2(LINE_SIZE);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CANON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_NL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF      = 3'd6;

    localparam logic       RST_CANON    = 1'b1;
    localparam logic       RST_ECHO     = 1'b1;
    localparam logic       RST_ECHO_NL  = 1'b0;
    localparam logic [2:0] RST_OUT_MODE = 3'd3;
    localparam logic [7:0] RST_ERASE    = 8'd127;
    localparam logic [7:0] RST_KILL     = 8'd21;
    localparam logic [7:0] RST_EOF      = 8'd4;

    localparam int OM_PROC   = 0;
    localparam int OM_NLCRLF = 1;
    localparam int OM_CRNL   = 2;

    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_SP = 8'h20;
    localparam logic [7:0] BYTE_NL = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam logic CH_TERM   = 1'b0;
    localparam logic CH_READER = 1'b1;
    localparam logic ACT_RX    = 1'b0;
    localparam logic ACT_TX    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TX_CR,
        ST_TX,
        ST_PASS,
        ST_ECHO,
        ST_RUB,
        ST_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        SEL_IN,
        SEL_TX,
        SEL_CR,
        SEL_RUB,
        SEL_STORE
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      store;
        logic      len_dec;
        logic      len_clr;
        logic      rub_one;
        logic      rub_len;
        logic      rub_step;
        logic      idx_clr;
        logic      idx_step;
        logic      emit;
        t_emit_sel sel;
        logic      chan;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tx;
        logic tx_crlf;
        logic canon;
        logic is_erase;
        logic is_kill;
        logic is_eof;
        logic is_nl;
        logic echo_en;
        logic echo_char;
        logic len_zero;
        logic rub_end;
        logic commit_end;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/tle_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the terminal line editor.
// Depends on tle_pkg; drives tle_dp through command and status structs.
module tle_ctrl
    import tle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                priority if (i_status.is_tx) begin
                    n_state = i_status.tx_crlf ? ST_TX_CR : ST_TX;
                end else if (!i_status.canon) begin
                    n_state = ST_PASS;
                end else if (i_status.is_erase || i_status.is_kill) begin
                    n_state = (!i_status.len_zero && i_status.echo_en) ? ST_RUB : ST_IDLE;
                end else if (i_status.is_eof) begin
                    n_state = i_status.len_zero ? ST_IDLE : ST_COMMIT;
                end else if (i_status.echo_char) begin
                    n_state = ST_ECHO;
                end else begin
                    n_state = i_status.is_nl ? ST_COMMIT : ST_IDLE;
                end
            end
            ST_TX_CR: begin
                if (i_status.out_free) n_state = ST_TX;
            end
            ST_TX, ST_PASS: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            ST_ECHO: begin
                if (i_status.out_free) n_state = i_status.is_nl ? ST_COMMIT : ST_IDLE;
            end
            ST_RUB: begin
                if (i_status.out_free && i_status.rub_end) n_state = ST_IDLE;
            end
            ST_COMMIT: begin
                if (i_status.out_free && i_status.commit_end) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                priority if (i_status.is_tx || !i_status.canon) begin
                    o_cmd.load = 1'b0;
                end else if (i_status.is_erase) begin
                    o_cmd.len_dec = !i_status.len_zero;
                    o_cmd.rub_one = 1'b1;
                end else if (i_status.is_kill) begin
                    o_cmd.rub_len = 1'b1;
                    o_cmd.len_clr = 1'b1;
                end else if (i_status.is_eof) begin
                    o_cmd.idx_clr = 1'b1;
                end else begin
                    o_cmd.store   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                end
            end
            ST_TX_CR: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_CR;
                o_cmd.chan = CH_TERM;
            end
            ST_TX: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_TX;
                o_cmd.chan = CH_TERM;
                o_cmd.last = 1'b1;
            end
            ST_PASS: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_IN;
                o_cmd.chan = CH_READER;
                o_cmd.last = 1'b1;
            end
            ST_ECHO: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_IN;
                o_cmd.chan = CH_TERM;
                o_cmd.last = !i_status.is_nl;
            end
            ST_RUB: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.rub_step = i_status.out_free;
                o_cmd.sel      = SEL_RUB;
                o_cmd.chan     = CH_TERM;
                o_cmd.last     = i_status.rub_end;
            end
            ST_COMMIT: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.idx_step = i_status.out_free;
                o_cmd.len_clr  = i_status.out_free && i_status.commit_end;
                o_cmd.sel      = SEL_STORE;
                o_cmd.chan     = CH_READER;
                o_cmd.last     = i_status.commit_end;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/tle_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the terminal line editor: registers, line store, counters,
// output register. Depends on tle_pkg; commanded by tle_ctrl.
module tle_dp
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_action,
    input  logic [7:0]           i_byte_in,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output logic                 o_channel,
    output logic [7:0]           o_byte_out,
    output logic                 o_last
);

    logic       r_canon;
    logic       r_echo;
    logic       r_echo_nl;
    logic [2:0] r_out_mode;
    logic [7:0] r_erase;
    logic [7:0] r_kill;
    logic [7:0] r_eof;

    logic       r_action;
    logic [7:0] r_byte;

    logic [7:0]       r_line [LINE_SIZE];
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] r_rub_cnt;
    logic [1:0]       r_phase;

    logic       r_out_valid;
    logic       r_channel;
    logic [7:0] r_byte_out;
    logic       r_last;

    logic       len_full;
    logic       out_free;
    logic [7:0] tx_byte;
    logic [7:0] rub_byte;
    logic [7:0] n_byte_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon    <= RST_CANON;
            r_echo     <= RST_ECHO;
            r_echo_nl  <= RST_ECHO_NL;
            r_out_mode <= RST_OUT_MODE;
            r_erase    <= RST_ERASE;
            r_kill     <= RST_KILL;
            r_eof      <= RST_EOF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CANON:    r_canon    <= i_cfg_data[0];
                CFG_ECHO:     r_echo     <= i_cfg_data[0];
                CFG_ECHO_NL:  r_echo_nl  <= i_cfg_data[0];
                CFG_OUT_MODE: r_out_mode <= i_cfg_data[2:0];
                CFG_ERASE:    r_erase    <= i_cfg_data;
                CFG_KILL:     r_kill     <= i_cfg_data;
                CFG_EOF:      r_eof      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_byte   <= i_byte_in;
        end
    end

    assign len_full = (r_len == LEN_W'(LINE_SIZE - 1));
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !len_full) begin
            r_line[r_len] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_clr) begin
            r_len <= '0;
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - LEN_W'(1);
        end else if (i_cmd.store && !len_full) begin
            r_len <= r_len + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rub_cnt <= '0;
            r_phase   <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_step) begin
                r_idx <= r_idx + LEN_W'(1);
            end
            if (i_cmd.rub_one) begin
                r_rub_cnt <= LEN_W'(1);
                r_phase   <= '0;
            end else if (i_cmd.rub_len) begin
                r_rub_cnt <= r_len;
                r_phase   <= '0;
            end else if (i_cmd.rub_step) begin
                if (r_phase == 2'd2) begin
                    r_phase   <= '0;
                    r_rub_cnt <= r_rub_cnt - LEN_W'(1);
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end
        end
    end

    assign tx_byte = (r_out_mode[OM_PROC] && r_out_mode[OM_CRNL] && r_byte == BYTE_CR)
                   ? BYTE_NL : r_byte;
    assign rub_byte = (r_phase == 2'd1) ? BYTE_SP : BYTE_BS;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_IN:    n_byte_out = r_byte;
            SEL_TX:    n_byte_out = tx_byte;
            SEL_CR:    n_byte_out = BYTE_CR;
            SEL_RUB:   n_byte_out = rub_byte;
            default:   n_byte_out = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // line store is read straight into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_channel  <= i_cmd.chan;
            r_byte_out <= (i_cmd.sel == SEL_STORE) ? r_line[r_idx] : n_byte_out;
            r_last     <= i_cmd.last;
        end
    end

    always_comb begin
        o_status.is_tx      = (r_action == ACT_TX);
        o_status.tx_crlf    = r_out_mode[OM_PROC] && r_out_mode[OM_NLCRLF]
                              && (r_byte == BYTE_NL);
        o_status.canon      = r_canon;
        o_status.is_erase   = (r_byte == r_erase);
        o_status.is_kill    = (r_byte == r_kill);
        o_status.is_eof     = (r_byte == r_eof);
        o_status.is_nl      = (r_byte == BYTE_NL);
        o_status.echo_en    = r_echo;
        o_status.echo_char  = r_echo || ((r_byte == BYTE_NL) && r_echo_nl);
        o_status.len_zero   = (r_len == '0);
        o_status.rub_end    = (r_phase == 2'd2) && (r_rub_cnt == LEN_W'(1));
        o_status.commit_end = (r_idx == r_len - LEN_W'(1));
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_channel;
    assign o_byte_out  = r_byte_out;
    assign o_last      = r_last;

endmodule

// ===== design/tty_line_editor_core.sv =====
`timescale 1ns / 1ps
// Top level of the terminal line editor: controller plus datapath.
// Depends on tle_pkg, tle_ctrl and tle_dp.

// One item at a time: an accepted byte is decoded and then yields its N
// result bytes, where N is its result count (0 to 3 * (LINE_SIZE - 1), 45
// at LINE_SIZE 16). Results leave through a single output register at one
// byte per cycle while the output side does not stall; the next byte is
// accepted in the cycle after the final result of the previous one is
// loaded into that register. In canonical mode, erase echoes BS SP BS and
// kill echoes it once per pending byte when echo is on, and a newline
// or end-of-file streams the pending line to the reader; the last flag marks
// the final result of each item. Configuration writes are always ready and
// must only be made while the block is idle.
module tty_line_editor_core
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [7:0]           i_byte_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_channel,
    output logic [7:0]           o_byte_out,
    output logic                 o_last
);

    t_dp_cmd    s_cmd;
    t_dp_status s_status;

    assign o_cfg_ready = 1'b1;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    tle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_action),
        .i_byte_in   (i_byte_in),
        .i_out_ready (i_out_ready),
        .i_cmd       (s_cmd),
        .o_status    (s_status),
        .o_out_valid (o_out_valid),
        .o_channel   (o_channel),
        .o_byte_out  (o_byte_out),
        .o_last      (o_last)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !s_cmd.emit)
        else $error("result emitted while idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("held result overwritten");
`endif

endmodule

// ===== tb/tty_line_editor_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tty_line_editor_core: random and directed byte traffic,
// with a scoreboard class that predicts every emitted byte.
// Depends on tle_pkg and the tty_line_editor_core RTL.
import tle_pkg::*;

typedef struct packed {
    logic       channel;
    logic [7:0] data;
    logic       last;
} t_tty_result;

class tty_scoreboard;
    logic       canonical;
    logic       echo_on;
    logic       echo_nl;
    logic [2:0] out_mode;
    logic [7:0] erase_ch;
    logic [7:0] kill_ch;
    logic [7:0] eof_ch;
    logic [7:0] pending_line [LINE_SIZE];
    int         pending_len;
    t_tty_result expected_bytes[$];
    int         mismatches;
    int         checked;

    function new();
        canonical   = RST_CANON;
        echo_on     = RST_ECHO;
        echo_nl     = RST_ECHO_NL;
        out_mode    = RST_OUT_MODE;
        erase_ch    = RST_ERASE;
        kill_ch     = RST_KILL;
        eof_ch      = RST_EOF;
        pending_len = 0;
        mismatches  = 0;
        checked     = 0;
    endfunction

    function int outstanding();
        return expected_bytes.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        case (idx)
            CFG_CANON:    canonical = val[0];
            CFG_ECHO:     echo_on   = val[0];
            CFG_ECHO_NL:  echo_nl   = val[0];
            CFG_OUT_MODE: out_mode  = val[2:0];
            CFG_ERASE:    erase_ch  = val;
            CFG_KILL:     kill_ch   = val;
            CFG_EOF:      eof_ch    = val;
            default: ;
        endcase
    endfunction

    function void expect_byte(logic ch, logic [7:0] b);
        t_tty_result r;
        r.channel = ch;
        r.data    = b;
        r.last    = 1'b0;
        expected_bytes.push_back(r);
    endfunction

    function void expect_rubout();
        expect_byte(CH_TERM, BYTE_BS);
        expect_byte(CH_TERM, BYTE_SP);
        expect_byte(CH_TERM, BYTE_BS);
    endfunction

    function void flush_line();
        for (int i = 0; i < pending_len; i++)
            expect_byte(CH_READER, pending_line[i]);
        pending_len = 0;
    endfunction

    // Line discipline prediction for one accepted transaction.
    function void note_input(logic act, logic [7:0] b);
        int          first;
        t_tty_result tail;
        first = expected_bytes.size();
        if (act == ACT_TX) begin
            if (out_mode[OM_PROC] && b == BYTE_NL && out_mode[OM_NLCRLF]) begin
                expect_byte(CH_TERM, BYTE_CR);
                expect_byte(CH_TERM, BYTE_NL);
            end else if (out_mode[OM_PROC] && b == BYTE_CR && out_mode[OM_CRNL]) begin
                expect_byte(CH_TERM, BYTE_NL);
            end else begin
                expect_byte(CH_TERM, b);
            end
        end else if (!canonical) begin
            expect_byte(CH_READER, b);
        end else if (b == erase_ch) begin
            if (pending_len > 0) begin
                pending_len--;
                if (echo_on)
                    expect_rubout();
            end
        end else if (b == kill_ch) begin
            if (echo_on)
                repeat (pending_len) expect_rubout();
            pending_len = 0;
        end else if (b == eof_ch) begin
            flush_line();
        end else begin
            if (pending_len < LINE_SIZE - 1) begin
                pending_line[pending_len] = b;
                pending_len++;
            end
            if (echo_on || (b == BYTE_NL && echo_nl))
                expect_byte(CH_TERM, b);
            if (b == BYTE_NL)
                flush_line();
        end
        if (expected_bytes.size() > first) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    task report(string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task check_result(logic ch, logic [7:0] b, logic lst);
        t_tty_result want;
        checked++;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte ch=%0d data=%02h last=%0d", ch, b, lst));
            return;
        end
        want = expected_bytes.pop_front();
        if (ch !== want.channel)
            report($sformatf("result %0d channel %0d, want %0d", checked, ch, want.channel));
        if (b !== want.data)
            report($sformatf("result %0d data %02h, want %02h", checked, b, want.data));
        if (lst !== want.last)
            report($sformatf("result %0d last %0d, want %0d", checked, lst, want.last));
    endtask
endclass

module tty_line_editor_core_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic       act;
        logic [7:0] data;
        bit         drain_first;
    } t_tty_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CANON;
    logic [7:0]           i_cfg_data  = 8'h00;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_action    = ACT_RX;
    logic [7:0]           i_byte_in   = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_channel;
    logic [7:0]           o_byte_out;
    logic                 o_last;

    tty_scoreboard sb;
    t_tty_item     send_q[$];
    logic [7:0]    reg_plan [8];
    logic [CFG_IDX_W-1:0] reg_order [7] = '{CFG_CANON, CFG_ECHO, CFG_ECHO_NL, CFG_OUT_MODE,
                                            CFG_ERASE, CFG_KILL, CFG_EOF};
    bit tx_eager   = 1'b0;
    bit rx_eager   = 1'b0;
    int drain_mark = -1;
    int cycle_count = 0;

    tty_line_editor_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_byte_in   (i_byte_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_channel   (o_channel),
        .o_byte_out  (o_byte_out),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_count, sb.outstanding());
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_item(input logic act, input logic [7:0] b);
        t_tty_item it;
        it.act         = act;
        it.data        = b;
        it.drain_first = (send_q.size() == drain_mark);
        send_q.push_back(it);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == reg_plan[CFG_ERASE] || b == reg_plan[CFG_KILL] ||
               b == reg_plan[CFG_EOF] || b == BYTE_NL);
        return b;
    endfunction

    // Mostly edited lines with random content, some noise.
    task automatic queue_random_traffic(input int count);
        int         made;
        int         len;
        logic [7:0] b;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(0, 18);
                for (int k = 0; k < len; k++) begin
                    b = ($urandom_range(0, 7) == 0) ? reg_plan[CFG_ERASE] : plain_byte();
                    add_item(ACT_RX, b);
                    made++;
                    if ($urandom_range(0, 9) == 0) begin
                        add_item(ACT_TX, 8'($urandom_range(0, 255)));
                        made++;
                    end
                end
                case ($urandom_range(0, 3))
                    0, 1:    add_item(ACT_RX, BYTE_NL);
                    2:       add_item(ACT_RX, reg_plan[CFG_EOF]);
                    default: add_item(ACT_RX, reg_plan[CFG_KILL]);
                endcase
                made++;
            end else begin
                case ($urandom_range(0, 5))
                    0:       b = BYTE_NL;
                    1:       b = BYTE_CR;
                    2:       b = reg_plan[CFG_ERASE];
                    3:       b = reg_plan[CFG_KILL];
                    4:       b = reg_plan[CFG_EOF];
                    default: b = 8'($urandom_range(0, 255));
                endcase
                add_item(1'($urandom_range(0, 1)), b);
                made++;
            end
        end
    endtask

    task automatic drive_items();
        t_tty_item it;
        int        gap;
        while (send_q.size() > 0) begin
            it = send_q.pop_front();
            if (it.drain_first) begin
                do @(posedge i_clk);
                while (sb.outstanding() > 0);
            end
            i_in_valid <= 1'b1;
            i_action   <= it.act;
            i_byte_in  <= it.data;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            sb.note_input(it.act, it.data);
            gap = tx_eager ? 0 : $urandom_range(0, 15);
            if (gap > 0 || send_q.size() == 0 || send_q[0].drain_first) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic program_registers();
        foreach (reg_order[i]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_order[i];
            i_cfg_data  <= reg_plan[reg_order[i]];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(reg_order[i], reg_plan[reg_order[i]]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_idle(input int settle);
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_plan(input logic canon, input logic echo, input logic echo_nl,
                            input logic [2:0] om, input logic [7:0] erase,
                            input logic [7:0] kill, input logic [7:0] eof);
        reg_plan[CFG_CANON]    = {7'd0, canon};
        reg_plan[CFG_ECHO]     = {7'd0, echo};
        reg_plan[CFG_ECHO_NL]  = {7'd0, echo_nl};
        reg_plan[CFG_OUT_MODE] = {5'd0, om};
        reg_plan[CFG_ERASE]    = erase;
        reg_plan[CFG_KILL]     = kill;
        reg_plan[CFG_EOF]      = eof;
    endtask

    initial begin : result_sink
        int gap;
        bit held;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_eager ? 0 : $urandom_range(0, 15);
            if (!held && sb.checked >= 150 && i_in_valid) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_channel, o_byte_out, o_last);
        end
    end

    initial begin : stimulus
        sb = new();
        set_plan(RST_CANON, RST_ECHO, RST_ECHO_NL, RST_OUT_MODE, RST_ERASE, RST_KILL, RST_EOF);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: output processing, editing keys, empty-line corners
        add_item(ACT_TX, BYTE_NL);
        add_item(ACT_TX, BYTE_CR);
        add_item(ACT_TX, 8'h00);
        add_item(ACT_TX, 8'hFF);
        add_item(ACT_RX, RST_ERASE);
        add_item(ACT_RX, RST_KILL);
        add_item(ACT_RX, 8'h00);
        add_item(ACT_RX, 8'hFF);
        add_item(ACT_RX, RST_ERASE);
        add_item(ACT_RX, RST_KILL);
        add_item(ACT_RX, RST_EOF);
        add_item(ACT_RX, BYTE_NL);
        add_item(ACT_RX, "h");
        add_item(ACT_RX, "i");
        add_item(ACT_RX, RST_EOF);
        add_item(ACT_RX, "a");
        add_item(ACT_RX, "b");
        add_item(ACT_RX, "c");
        add_item(ACT_RX, BYTE_NL);
        drive_items();

        for (int phase = 1; phase <= 6; phase++) begin
            wait_for_idle(8);
            case (phase)
                1: set_plan(1'b1, 1'b0, 1'b1, 3'd7, 8'h00, 8'hFF, 8'h04);
                2: set_plan(1'b0, 1'b1, 1'b1, 3'd0, RST_ERASE, RST_KILL, RST_EOF);
                3: set_plan(1'b1, 1'b1, 1'b0, 3'd5, 8'hFF, 8'hFF, 8'hFF);
                4: set_plan(1'b1, 1'b1, 1'b0, 3'd6, 8'hFF, 8'h15, 8'h15);
                default: set_plan(1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
            endcase
            program_registers();
            tx_eager   = (phase == 3);
            rx_eager   = (phase == 5);
            drain_mark = (phase == 2) ? 10 : -1;
            queue_random_traffic(26);
            drive_items();
        end

        wait_for_idle(20);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== tty_line_editor_core.f =====
design/tle_pkg.sv
design/tle_ctrl.sv
design/tle_dp.sv
design/tty_line_editor_core.sv
tb/tty_line_editor_core_test.sv
